@@ rtl/srr_pkg.sv @@
package srr_pkg;

  localparam int SEQ_W           = 31;
  localparam int WORD_W          = 32;
  localparam int PAYLOAD_WORDS   = 5;
  localparam int WINDOW_SIZE_DEF = 8;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [SEQ_W-1:0] ACK_BASE_ZERO_RST = 31'd8;
  localparam logic [SEQ_W-1:0] SEQ_MAX           = '1;

  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  typedef logic [PAYLOAD_WORDS-1:0][WORD_W-1:0] payload_t;

  typedef struct packed {
    logic [SEQ_W-1:0]         seq_num;
    logic signed [WORD_W-1:0] ack_num;
    logic signed [WORD_W-1:0] check_sum;
    logic [WORD_W-1:0]        payload_w0;
    logic [WORD_W-1:0]        payload_w1;
    logic [WORD_W-1:0]        payload_w2;
    logic [WORD_W-1:0]        payload_w3;
    logic [WORD_W-1:0]        payload_w4;
  } pkt_t;

  typedef struct packed {
    logic                     kind;
    logic signed [WORD_W-1:0] ack_number;
    logic signed [WORD_W-1:0] ack_check;
    logic [WORD_W-1:0]        out_w0;
    logic [WORD_W-1:0]        out_w1;
    logic [WORD_W-1:0]        out_w2;
    logic [WORD_W-1:0]        out_w3;
    logic [WORD_W-1:0]        out_w4;
    logic                     last;
  } res_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic             ok;
    payload_t         payload;
  } qent_t;

endpackage

@@ rtl/srr_front.sv @@
module srr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  srr_pkg::pkt_t in_pkt,
  output logic          push,
  output srr_pkg::qent_t push_ent,
  input  logic          q_full
);

  logic          f_valid;
  srr_pkg::pkt_t f_pkt;
  logic          accept;
  logic signed [9:0] ws0, ws1, ws2, ws3, ws4;
  logic [srr_pkg::WORD_W-1:0] total;

  // sum of four bytes, each taken as signed
  function automatic logic signed [9:0] word_sum(input logic [31:0] w);
    word_sum = 10'(signed'(w[7:0])) + 10'(signed'(w[15:8]))
             + 10'(signed'(w[23:16])) + 10'(signed'(w[31:24]));
  endfunction

  assign in_stall = f_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = f_valid && !q_full;

  always_comb begin
    ws0   = word_sum(f_pkt.payload_w0);
    ws1   = word_sum(f_pkt.payload_w1);
    ws2   = word_sum(f_pkt.payload_w2);
    ws3   = word_sum(f_pkt.payload_w3);
    ws4   = word_sum(f_pkt.payload_w4);
    total = 32'({1'b0, f_pkt.seq_num}) + f_pkt.ack_num
          + 32'(ws0) + 32'(ws1) + 32'(ws2) + 32'(ws3) + 32'(ws4);
    push_ent.seq     = f_pkt.seq_num;
    push_ent.ok      = (total == f_pkt.check_sum);
    push_ent.payload = {f_pkt.payload_w4, f_pkt.payload_w3, f_pkt.payload_w2,
                        f_pkt.payload_w1, f_pkt.payload_w0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_pkt <= in_pkt;
    end
  end

endmodule

@@ rtl/srr_queue.sv @@
module srr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  srr_pkg::qent_t push_ent,
  output logic           full,
  input  logic           pop,
  output srr_pkg::qent_t head,
  output logic           nonempty
);

  srr_pkg::qent_t ent [srr_pkg::QUEUE_DEPTH];
  logic [srr_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [srr_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [srr_pkg::QUEUE_PTR_W:0]   count;
  logic do_push;
  logic do_pop;

  assign full     = (count == (srr_pkg::QUEUE_PTR_W+1)'(srr_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign head     = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == srr_pkg::QUEUE_PTR_W'(srr_pkg::QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == srr_pkg::QUEUE_PTR_W'(srr_pkg::QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wr_ptr] <= push_ent;
    end
  end

endmodule

@@ rtl/srr_back.sv @@
module srr_back #(
  parameter int WINDOW_SIZE = srr_pkg::WINDOW_SIZE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [srr_pkg::SEQ_W-1:0] cfg_data,
  input  logic                      q_nonempty,
  input  srr_pkg::qent_t            head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output srr_pkg::res_t             out_res
);

  localparam int IDXW = $clog2(WINDOW_SIZE);
  localparam logic [IDXW:0] W_C = (IDXW+1)'(WINDOW_SIZE);
  localparam int unsigned WRAP_REM_I = 32'h8000_0000 % WINDOW_SIZE;
  localparam logic [IDXW:0] WRAP_REM = (IDXW+1)'(WRAP_REM_I);

  typedef enum logic [1:0] {
    S_TAKE = 2'b01,
    S_SEND = 2'b10
  } state_t;

  state_t state, state_next;
  logic [srr_pkg::SEQ_W-1:0] ack_base_zero;
  logic [srr_pkg::SEQ_W-1:0] base, base_next;
  logic [IDXW-1:0]           bidx, bidx_next;
  logic [WINDOW_SIZE-1:0]    filled, filled_next;
  srr_pkg::payload_t         mem [WINDOW_SIZE];
  srr_pkg::payload_t         rd_q;

  logic                      out_free;
  logic                      load;
  srr_pkg::res_t             res_next;
  logic [srr_pkg::SEQ_W-1:0] offset;
  logic                      in_win;
  logic                      take_pkt;
  logic                      wrapped;
  logic [IDXW:0]             r0, r1, slot;
  logic [IDXW-1:0]           slot_idx;
  logic                      wr_en;
  logic [WINDOW_SIZE-1:0]    filled_w, filled_c;
  logic                      more_t, more_s;
  logic [IDXW-1:0]           nidx;
  logic                      rd_en;
  logic [IDXW-1:0]           rd_addr;
  logic [srr_pkg::WORD_W-1:0] acknum;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    // slot of the arriving seq, from the base's slot plus the window offset
    offset   = head.seq - base;
    in_win   = offset < srr_pkg::SEQ_W'(WINDOW_SIZE);
    take_pkt = head.ok && in_win;
    wrapped  = head.seq < base;
    r0       = {1'b0, bidx} + (IDXW+1)'(offset[IDXW-1:0]);
    r1       = (r0 >= W_C) ? r0 - W_C : r0;
    if (!wrapped) begin
      slot = r1;
    end else if (r1 >= WRAP_REM) begin
      slot = r1 - WRAP_REM;
    end else begin
      slot = r1 + W_C - WRAP_REM;
    end
    slot_idx = slot[IDXW-1:0];

    if (take_pkt) begin
      acknum = {1'b0, head.seq};
    end else if (base == '0) begin
      acknum = {1'b0, ack_base_zero};
    end else begin
      acknum = {1'b0, base - 1'b1};
    end

    // next base slot, restarting at zero after the last slot or when the sequence wraps
    if (base == srr_pkg::SEQ_MAX || bidx == IDXW'(WINDOW_SIZE-1)) begin
      nidx = '0;
    end else begin
      nidx = bidx + 1'b1;
    end

    wr_en    = 1'b0;
    filled_w = filled | ((state == S_TAKE && take_pkt && !filled[slot_idx])
                         ? WINDOW_SIZE'(1) << slot_idx : '0);
    filled_c = filled & ~(WINDOW_SIZE'(1) << bidx);
    more_t   = filled_w[bidx];
    more_s   = filled_c[nidx];

    state_next  = state;
    base_next   = base;
    bidx_next   = bidx;
    filled_next = filled;
    rd_en       = 1'b0;
    rd_addr     = bidx;
    load        = 1'b0;
    pop         = 1'b0;
    res_next    = '0;

    case (state)
      S_TAKE: begin
        if (q_nonempty && out_free) begin
          pop                 = 1'b1;
          wr_en               = take_pkt && !filled[slot_idx];
          filled_next         = filled_w;
          rd_en               = more_t;
          load                = 1'b1;
          res_next.kind       = srr_pkg::KIND_ACK;
          res_next.ack_number = acknum;
          res_next.ack_check  = acknum - 32'd1;
          res_next.last       = !more_t;
          if (more_t) begin
            state_next = S_SEND;
          end
        end
      end
      S_SEND: begin
        if (out_free) begin
          load            = 1'b1;
          res_next.kind   = srr_pkg::KIND_DELIVER;
          res_next.out_w0 = rd_q[0];
          res_next.out_w1 = rd_q[1];
          res_next.out_w2 = rd_q[2];
          res_next.out_w3 = rd_q[3];
          res_next.out_w4 = rd_q[4];
          res_next.last   = !more_s;
          filled_next     = filled_c;
          base_next       = base + 1'b1;
          bidx_next       = nidx;
          rd_en           = more_s;
          rd_addr         = nidx;
          if (!more_s) begin
            state_next = S_TAKE;
          end
        end
      end
      default: begin
        state_next = S_TAKE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_TAKE;
      base          <= '0;
      bidx          <= '0;
      filled        <= '0;
      out_valid     <= 1'b0;
      ack_base_zero <= srr_pkg::ACK_BASE_ZERO_RST;
    end else begin
      state  <= state_next;
      base   <= base_next;
      bidx   <= bidx_next;
      filled <= filled_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        ack_base_zero <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res_next;
    end
  end

  // slot buffer, write-first on a read of the slot being written
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot_idx] <= head.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && slot_idx == rd_addr) begin
        rd_q <= head.payload;
      end else begin
        rd_q <= mem[rd_addr];
      end
    end
  end

endmodule

@@ rtl/selective_repeat_receiver.sv @@
// Selective-repeat receiver.
// Input channel (in_valid / in_stall / in_pkt): one data packet per request,
// with sequence number, ack field, checksum and five payload words.
// Output channel (out_valid / out_stall / out_res): per packet, one ack
// (kind 0) first, then zero or more in-order payload deliveries (kind 1);
// last marks the final result of the packet.
// cfg_we / cfg_data write the ack number used for rejected packets while the
// window base is zero; write it only while the block is idle.
// An ack passes through the front register, a queue entry and the output
// register. A packet with n deliveries yields 1 + n results, one result
// per cycle through the single output register while out_stall is low.
// The front end checks the checksum and feeds a two-entry queue, so it
// keeps taking packets while the back end drains deliveries.
// Reset (rst, synchronous): window base 0, all slots empty, queue and output
// empty, register back to 8. No clearing pass is needed.
// While out_stall is high the output holds its result, the back end waits,
// and in_stall rises once the queue and the front register are full.
module selective_repeat_receiver #(
  parameter int WINDOW_SIZE = srr_pkg::WINDOW_SIZE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  srr_pkg::pkt_t             in_pkt,
  output logic                      out_valid,
  input  logic                      out_stall,
  output srr_pkg::res_t             out_res,
  input  logic                      cfg_we,
  input  logic [srr_pkg::SEQ_W-1:0] cfg_data
);

  logic           push;
  srr_pkg::qent_t push_ent;
  logic           q_full;
  logic           pop;
  srr_pkg::qent_t head;
  logic           q_nonempty;

  srr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_pkt   (in_pkt),
    .push     (push),
    .push_ent (push_ent),
    .q_full   (q_full)
  );

  srr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_ent (push_ent),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .nonempty (q_nonempty)
  );

  srr_back #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .q_nonempty (q_nonempty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

endmodule
